// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files of the digit emitter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant violated");

// Check that a condition leads to a consequence in the next cycle
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequence check failed");

`endif

// ===== rtl/ntad_pkg.sv =====
// ----------------------------------------------------------------------------
// ntad_pkg
// Types and constants shared by the digit emitter front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ntad_pkg;

    // Format codes carried in the request opcode
    localparam logic [2:0] OP_U8_DEC  = 3'd0;
    localparam logic [2:0] OP_U8_BIN  = 3'd1;
    localparam logic [2:0] OP_U16_DEC = 3'd2;
    localparam logic [2:0] OP_S16_MAG = 3'd3;

    localparam logic [5:0] CH_ZERO = 6'd48;

    // Digit positions: 0 is ten-thousands, 4 is units
    localparam logic [2:0] POS_TENS_K = 3'd0;
    localparam logic [2:0] POS_HUND   = 3'd2;
    localparam logic [2:0] POS_TENS   = 3'd3;
    localparam logic [2:0] POS_UNITS  = 3'd4;
    localparam logic [2:0] POS_BIT_LAST = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [5:0] ascii_char;
        logic       last_char;
    } out_item_t;

    typedef enum logic {
        MODE_DEC,
        MODE_BIN
    } job_mode_t;

    // Classified work item handed from front to back
    typedef struct packed {
        job_mode_t   mode;
        logic [2:0]  first_pos;
        logic [15:0] mag;
    } job_t;

    // k times the place weight of digit position pos
    function automatic logic [16:0] dec_mult(input logic [2:0] pos, input int k);
        int weight;
        begin
            unique case (pos)
                3'd0:    weight = 10000;
                3'd1:    weight = 1000;
                3'd2:    weight = 100;
                3'd3:    weight = 10;
                default: weight = 1;
            endcase
            dec_mult = 17'(weight * k);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ntad_queue.sv =====
// ----------------------------------------------------------------------------
// ntad_queue
// Small FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ntad_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  ntad_pkg::job_t     push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output ntad_pkg::job_t     head_job
);
    import ntad_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        begin
            if (p == PTR_W'(DEPTH - 1)) begin
                bump = '0;
            end else begin
                bump = p + PTR_W'(1);
            end
        end
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store job payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_ALWAYS(a_queue_no_overrun, aclk, aresetn, !(push && full && !pop))
    `ASSERT_ALWAYS(a_queue_no_underrun, aclk, aresetn, !(pop && !head_valid))

endmodule

`default_nettype wire

// ===== rtl/ntad_front.sv =====
// ----------------------------------------------------------------------------
// ntad_front
// Accepts requests and classifies them into decimal or binary jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntad_front (
    input  wire logic           s_valid,
    output logic                s_ready,
    input  ntad_pkg::in_item_t  s_item,
    input  wire logic           q_full,
    output logic                push,
    output ntad_pkg::job_t      push_job
);
    import ntad_pkg::*;

    logic       job_ok;
    logic [7:0] low_byte;

    assign low_byte = s_item.value[7:0];
    assign s_ready  = !q_full;
    assign push     = s_valid && s_ready && job_ok;

    // Decode format, pick magnitude and first digit position
    always_comb begin
        job_ok             = 1'b1;
        push_job.mode      = MODE_DEC;
        push_job.first_pos = POS_TENS_K;
        push_job.mag       = s_item.value;
        unique case (s_item.opcode)
            OP_U8_DEC: begin
                push_job.mag = {8'd0, low_byte};
                if (low_byte >= 8'd100) begin
                    push_job.first_pos = POS_HUND;
                end else if (low_byte >= 8'd10) begin
                    push_job.first_pos = POS_TENS;
                end else begin
                    push_job.first_pos = POS_UNITS;
                end
            end
            OP_U8_BIN: begin
                push_job.mode = MODE_BIN;
                push_job.mag  = {low_byte, 8'd0};
            end
            OP_U16_DEC: begin
                push_job.mag = s_item.value;
            end
            OP_S16_MAG: begin
                // Negate negatives; the most negative value yields 0x8000
                push_job.mag = s_item.value[15] ? (~s_item.value + 16'd1) : s_item.value;
            end
            default: begin
                // Unsupported base: drop the request
                job_ok = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ntad_back.sv =====
// ----------------------------------------------------------------------------
// ntad_back
// Emits one ASCII character per cycle, unless stalled, from the queued jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ntad_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  ntad_pkg::job_t       q_job,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ntad_pkg::out_item_t  m_item
);
    import ntad_pkg::*;

    logic        cur_valid_reg, cur_valid_next;
    job_mode_t   cur_mode_reg, cur_mode_next;
    logic [2:0]  cur_pos_reg, cur_pos_next;
    logic [15:0] cur_rem_reg, cur_rem_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;

    logic [16:0] mult [10];
    logic [3:0]  dec_digit;
    logic [3:0]  digit;
    logic        emit;
    logic        is_last;

    // Compare remainder against every multiple of the place weight
    always_comb begin
        dec_digit = 4'd0;
        for (int k = 0; k < 10; k++) begin
            mult[k] = dec_mult(cur_pos_reg, k);
        end
        for (int k = 1; k < 10; k++) begin
            if ({1'b0, cur_rem_reg} >= mult[k]) begin
                dec_digit = 4'(k);
            end
        end
    end

    assign digit   = (cur_mode_reg == MODE_BIN) ? {3'd0, cur_rem_reg[15]} : dec_digit;
    assign is_last = (cur_mode_reg == MODE_BIN) ? (cur_pos_reg == POS_BIT_LAST)
                                                : (cur_pos_reg == POS_UNITS);
    assign emit    = cur_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop   = q_valid && (!cur_valid_reg || (emit && is_last));

    // Advance working job; load the next one when none is held or it ends
    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_mode_next  = cur_mode_reg;
        cur_pos_next   = cur_pos_reg;
        cur_rem_next   = cur_rem_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;
        if (emit) begin
            m_valid_next           = 1'b1;
            m_item_next.ascii_char = CH_ZERO + {2'd0, digit};
            m_item_next.last_char  = is_last;
            cur_pos_next           = cur_pos_reg + 3'd1;
            if (cur_mode_reg == MODE_BIN) begin
                cur_rem_next = {cur_rem_reg[14:0], 1'b0};
            end else begin
                cur_rem_next = 16'({1'b0, cur_rem_reg} - mult[dec_digit]);
            end
            if (is_last) begin
                cur_valid_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_mode_next  = q_job.mode;
            cur_pos_next   = q_job.first_pos;
            cur_rem_next   = q_job.mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        cur_mode_reg <= cur_mode_next;
        cur_pos_reg  <= cur_pos_next;
        cur_rem_reg  <= cur_rem_next;
        m_item_reg   <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ASSERT_ALWAYS(a_dec_pos_range, aclk, aresetn,
        !(cur_valid_reg && cur_mode_reg == MODE_DEC && cur_pos_reg > POS_UNITS))
    `ASSERT_NEXT(a_job_holds_on_stall, aclk, aresetn,
        cur_valid_reg && m_valid_reg && !m_ready,
        $stable(cur_pos_reg) && $stable(cur_rem_reg))
    `ASSERT_ALWAYS(a_char_is_digit, aclk, aresetn,
        !m_valid_reg || (m_item_reg.ascii_char <= CH_ZERO + 6'd9))

endmodule

`default_nettype wire

// ===== rtl/number_to_ascii_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_digit_emitter
// Turns a number and a format code into ASCII digit characters, MSB first.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready with s_item (opcode, value). Each
//   request yields a run of characters on m_valid/m_ready with m_item
//   (ascii_char, last_char); last_char marks the final character of a number.
//   Byte decimal gives 1 to 3 characters, byte binary 8, both 16-bit
//   decimal formats 5. Other opcodes are accepted and give no characters.
//   The first character passes through the job queue, the working job
//   registers and the output register. Throughput: one character per
//   cycle while the receiver is ready; a request has 1 to 8 characters,
//   and the character emitter is the limiting unit.
//   A QUEUE_DEPTH-entry job queue lets requests be taken while the back end
//   is still emitting; s_ready drops only when that queue is full.
//   When the receiver stalls, the output register holds its character and
//   the emitter waits; requests keep flowing in until the queue fills.
//   Reset (aresetn low, synchronous) empties the queue and the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module number_to_ascii_digit_emitter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  ntad_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ntad_pkg::out_item_t  m_item
);
    import ntad_pkg::*;

    logic q_full;
    logic push;
    job_t push_job;
    logic q_pop;
    logic q_valid;
    job_t q_job;

    // Classify incoming requests
    ntad_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // Buffer jobs between front and back
    ntad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_job)
    );

    // Emit characters
    ntad_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire
